// ===== rtl/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

    localparam int UNITS = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_A  = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [7:0] LEAD2_LO  = 8'hc2;
    localparam logic [7:0] LEAD2_HI  = 8'hdf;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD3_HI  = 8'hef;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] LEAD4_HI  = 8'hf4;
    localparam logic [7:0] LEAD_SURR = 8'hed;
    localparam logic [7:0] CONT_A0   = 8'ha0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8f;
    localparam logic [7:0] CONT_MASK = 8'hc0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       no_data;
    } jsu_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       binary_seen;
    } jsu_char_t;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_ESC,
        KIND_CTRL,
        KIND_FFFD
    } jsu_kind_t;

    typedef struct packed {
        jsu_kind_t  kind;
        logic [7:0] value;
    } jsu_unit_t;

    typedef struct packed {
        logic                  open_quote;
        logic [2:0]            cnt;
        jsu_unit_t [UNITS-1:0] units;
        logic                  close_quote;
        logic                  binary;
    } jsu_entry_t;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_UNIT,
        PH_CLOSE
    } jsu_phase_t;

endpackage

`default_nettype wire

// ===== rtl/jsu_front.sv =====
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire jsu_item_t  item,
    output logic            push,
    output jsu_entry_t      entry
);

    function automatic logic [2:0] seq_len(input logic [7:0] c);
        if (c >= LEAD2_LO && c <= LEAD2_HI) begin
            return 3'd2;
        end
        if (c >= LEAD3_LO && c <= LEAD3_HI) begin
            return 3'd3;
        end
        if (c >= LEAD4_LO && c <= LEAD4_HI) begin
            return 3'd4;
        end
        return 3'd0;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic [7:0] b,
                                     input logic [1:0] pos);
        if ((b & CONT_MASK) != 8'h80) begin
            return 1'b0;
        end
        if (pos == 2'd1) begin
            if (lead == LEAD3_LO && b < CONT_A0) begin
                return 1'b0;
            end
            if (lead == LEAD_SURR && b >= CONT_A0) begin
                return 1'b0;
            end
            if (lead == LEAD4_LO && b < CONT_90) begin
                return 1'b0;
            end
            if (lead == LEAD4_HI && b > CONT_8F) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic jsu_kind_t ascii_kind(input logic [7:0] b);
        if (b == CH_QUOTE || b == CH_BSLASH) begin
            return KIND_ESC;
        end
        if (b < CH_SPACE) begin
            return KIND_CTRL;
        end
        return KIND_RAW;
    endfunction

    logic       open_reg, open_next;
    logic [1:0] count_reg, count_next;
    logic       flag_reg, flag_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] cont_reg [2];
    logic [7:0] cont_next [2];

    logic       start;
    logic [1:0] hc;
    logic [7:0] b;
    logic       last;
    logic       nod;
    logic       ok;
    logic       complete;
    logic       flush;
    jsu_kind_t  held_kind;
    logic       new_emit;
    jsu_kind_t  new_kind;
    logic       fresh;
    logic [1:0] keep_cnt;
    logic       str_flag;
    logic [7:0] held4 [UNITS];

    assign start    = item.first_byte || !open_reg;
    assign hc       = start ? 2'd0 : count_reg;
    assign b        = item.data_byte;
    assign last     = item.last_byte;
    assign nod      = item.no_data;
    assign ok       = cont_ok(lead_reg, b, hc);
    assign complete = (({1'b0, hc} + 3'd1) == seq_len(lead_reg));

    assign held4[0] = lead_reg;
    assign held4[1] = cont_reg[0];
    assign held4[2] = cont_reg[1];
    assign held4[3] = b;

    // sort the held sequence and the new byte into output units
    always_comb
    begin
        flush        = 1'b0;
        held_kind    = KIND_FFFD;
        new_emit     = 1'b0;
        new_kind     = KIND_RAW;
        fresh        = 1'b0;
        keep_cnt     = 2'd0;
        lead_next    = lead_reg;
        cont_next[0] = cont_reg[0];
        cont_next[1] = cont_reg[1];
        if (hc != 2'd0)
        begin
            if (nod)
            begin
                if (last)
                begin
                    flush = 1'b1;
                end
                else
                begin
                    keep_cnt = hc;
                end
            end
            else if (ok)
            begin
                if (complete)
                begin
                    flush     = 1'b1;
                    held_kind = KIND_RAW;
                    new_emit  = 1'b1;
                    new_kind  = KIND_RAW;
                end
                else if (last)
                begin
                    flush    = 1'b1;
                    new_emit = 1'b1;
                    new_kind = KIND_FFFD;
                end
                else
                begin
                    keep_cnt = hc + 2'd1;
                    if (hc == 2'd1)
                    begin
                        cont_next[0] = b;
                    end
                    else
                    begin
                        cont_next[1] = b;
                    end
                end
            end
            else
            begin
                flush = 1'b1;
                fresh = 1'b1;
            end
        end
        else
        begin
            fresh = !nod;
        end
        if (fresh)
        begin
            if (!b[7])
            begin
                new_emit = 1'b1;
                new_kind = ascii_kind(b);
            end
            else if (seq_len(b) == 3'd0 || last)
            begin
                new_emit = 1'b1;
                new_kind = KIND_FFFD;
            end
            else
            begin
                keep_cnt  = 2'd1;
                lead_next = b;
            end
        end
    end

    assign str_flag = (start ? 1'b0 : flag_reg)
                    | (flush && held_kind == KIND_FFFD)
                    | (new_emit && (new_kind == KIND_FFFD
                                    || (new_kind == KIND_CTRL && b == 8'h00)));

    always_comb
    begin
        entry.open_quote  = start;
        entry.close_quote = last;
        entry.binary      = str_flag;
        entry.cnt         = flush ? ({1'b0, hc} + {2'b00, new_emit}) : {2'b00, new_emit};
        for (int i = 0; i < UNITS; i++)
        begin
            if (2'(i) == hc)
            begin
                entry.units[i] = '{kind: new_kind, value: b};
            end
            else
            begin
                entry.units[i] = '{kind: held_kind, value: held4[i]};
            end
        end
    end

    assign push       = take && (start || entry.cnt != 3'd0 || last);
    assign open_next  = !last;
    assign count_next = last ? 2'd0 : keep_cnt;
    assign flag_next  = last ? 1'b0 : str_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= 2'd0;
            flag_reg  <= 1'b0;
        end
        else if (take)
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lead_reg    <= lead_next;
            cont_reg[0] <= cont_next[0];
            cont_reg[1] <= cont_next[1];
        end
    end

    // a held sequence is always a proper prefix of a valid lead
    a_held_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd0 |-> seq_len(lead_reg) != 3'd0
                              && {1'b0, count_reg} < seq_len(lead_reg))
        else $error("held bytes do not form a partial sequence");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> count_reg == 2'd0 && !flag_reg)
        else $error("string state left over between strings");

endmodule

`default_nettype wire

// ===== rtl/jsu_queue.sv =====
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire jsu_entry_t  push_entry,
    input  wire logic        pop,
    output jsu_entry_t       head,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_entry_t    slot_reg [DEPTH];
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW-1:0] wr_reg, wr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head  = slot_reg[rd_reg];
    assign empty = (count_reg == CW'(0));
    assign full  = (count_reg == CW'(DEPTH));

    assign rd_next = (rd_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_reg + PW'(1);
    assign wr_next = (wr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_reg + PW'(1);

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            wr_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        have_entry,
    input  wire jsu_entry_t  entry,
    output logic             pop,
    output logic             char_valid,
    input  wire logic        char_stall,
    output jsu_char_t        char_data
);

    function automatic logic [2:0] unit_last_sub(input jsu_kind_t k);
        unique case (k)
            KIND_RAW:  return 3'd0;
            KIND_ESC:  return 3'd1;
            KIND_CTRL: return 3'd5;
            KIND_FFFD: return 3'd5;
            default:   return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + {4'h0, n} : CH_HEX_A + {4'h0, n} - 8'd10;
    endfunction

    jsu_phase_t phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] sub_reg, sub_next;
    logic       valid_reg;
    jsu_char_t  data_reg, data_next;

    jsu_phase_t cur_phase;
    jsu_unit_t  unit;
    logic [2:0] last_sub;
    logic       more;
    logic       load;

    assign unit     = entry.units[idx_reg];
    assign last_sub = unit_last_sub(unit.kind);
    assign load     = have_entry && (!valid_reg || !char_stall);
    assign pop      = load && !more;

    // skip steps that the entry does not have
    always_comb
    begin
        cur_phase = phase_reg;
        if (phase_reg == PH_OPEN && !entry.open_quote)
        begin
            cur_phase = PH_UNIT;
        end
        if (cur_phase == PH_UNIT && {1'b0, idx_reg} >= entry.cnt)
        begin
            cur_phase = PH_CLOSE;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sub_next   = sub_reg;
        more       = 1'b0;
        unique case (cur_phase)
            PH_OPEN:
            begin
                phase_next = PH_UNIT;
                idx_next   = 2'd0;
                sub_next   = 3'd0;
                more       = (entry.cnt != 3'd0) || entry.close_quote;
            end
            PH_UNIT:
            begin
                if (sub_reg == last_sub)
                begin
                    sub_next = 3'd0;
                    if (({1'b0, idx_reg} + 3'd1) < entry.cnt)
                    begin
                        phase_next = PH_UNIT;
                        idx_next   = idx_reg + 2'd1;
                        more       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CLOSE;
                        more       = entry.close_quote;
                    end
                end
                else
                begin
                    phase_next = PH_UNIT;
                    sub_next   = sub_reg + 3'd1;
                    more       = 1'b1;
                end
            end
            PH_CLOSE:
            begin
                more = 1'b0;
            end
            default:
            begin
                more = 1'b0;
            end
        endcase
        if (!more)
        begin
            phase_next = PH_OPEN;
            idx_next   = 2'd0;
            sub_next   = 3'd0;
        end
    end

    always_comb
    begin
        data_next = '{out_char: CH_QUOTE, last_char: 1'b0, binary_seen: 1'b0};
        unique case (cur_phase)
            PH_OPEN:
            begin
                data_next.out_char = CH_QUOTE;
            end
            PH_CLOSE:
            begin
                data_next.last_char   = 1'b1;
                data_next.binary_seen = entry.binary;
            end
            PH_UNIT:
            begin
                unique case (unit.kind)
                    KIND_RAW:
                    begin
                        data_next.out_char = unit.value;
                    end
                    KIND_ESC:
                    begin
                        data_next.out_char = (sub_reg == 3'd0) ? CH_BSLASH : unit.value;
                    end
                    KIND_CTRL:
                    begin
                        case (sub_reg)
                            3'd0:    data_next.out_char = CH_BSLASH;
                            3'd1:    data_next.out_char = CH_U;
                            3'd4:    data_next.out_char = hex_char(unit.value[7:4]);
                            3'd5:    data_next.out_char = hex_char(unit.value[3:0]);
                            default: data_next.out_char = CH_ZERO;
                        endcase
                    end
                    KIND_FFFD:
                    begin
                        case (sub_reg)
                            3'd0:    data_next.out_char = CH_BSLASH;
                            3'd1:    data_next.out_char = CH_U;
                            3'd5:    data_next.out_char = CH_D;
                            default: data_next.out_char = CH_F;
                        endcase
                    end
                    default:
                    begin
                        data_next.out_char = unit.value;
                    end
                endcase
            end
            default:
            begin
                data_next.out_char = CH_QUOTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            idx_reg   <= 2'd0;
            sub_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                sub_reg   <= sub_next;
                valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign char_valid = valid_reg;
    assign char_data  = data_reg;

    // the cursor only leaves its start position while an entry is at the queue head
    a_cursor_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_OPEN || idx_reg != 2'd0 || sub_reg != 3'd0) |-> have_entry)
        else $error("expansion cursor advanced without an entry");

    a_close_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        load && data_next.last_char |=> char_data.out_char == CH_QUOTE && pop == 1'b0
                                        || char_data.out_char == CH_QUOTE)
        else $error("string closed on a character other than a quote");

endmodule

`default_nettype wire

// ===== rtl/json_string_utf8_sanitizer.sv =====
// channel | side | handshake              | word
// byte    | in   | byte_valid, byte_stall | jsu_item_t: data_byte, first_byte, last_byte, no_data
// char    | out  | char_valid, char_stall | jsu_char_t: out_char, last_char, binary_seen
//
// one input word per cycle while the queue has room; byte_stall is high when it is full
// each input word expands to 0..25 output chars, one per cycle from the back end cursor unless stalled
// with an empty queue and a free output register, an accepted word passes the queue, then the output register
// rst_n clears string state, queue pointers, the back end cursor and output valid; nothing else to clear
// char_stall holds the output register; the queue of QUEUE_DEPTH entries absorbs expansion
`default_nettype none

module json_string_utf8_sanitizer
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire jsu_item_t  byte_data,
    output logic            char_valid,
    input  wire logic       char_stall,
    output jsu_char_t       char_data
);

    logic       take;
    logic       push;
    jsu_entry_t push_entry;
    logic       pop;
    jsu_entry_t head;
    logic       empty;
    logic       full;

    assign byte_stall = full;
    assign take       = byte_valid && !full;

    jsu_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_data),
        .push  (push),
        .entry (push_entry)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .have_entry (!empty),
        .entry      (head),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import jsu_pkg::*;

    typedef enum {SEQ_PARTIAL, SEQ_COMPLETE, SEQ_BROKEN} seq_verdict_t;

    class json_literal_scoreboard;
        jsu_char_t  want_chars[$];
        logic [7:0] held_lead;
        logic [7:0] held_cont[2];
        int         held_count;
        bit         binary_flag;
        bit         in_string;
        int         errors;

        function new();
            clear_string();
            errors = 0;
        endfunction

        function void clear_string();
            held_lead = '0;
            held_cont[0] = '0;
            held_cont[1] = '0;
            held_count = 0;
            binary_flag = 1'b0;
            in_string = 1'b0;
        endfunction

        function int pending();
            return want_chars.size();
        endfunction

        function void add(logic [7:0] ch, logic lastc = 1'b0, logic bin = 1'b0);
            jsu_char_t c;
            c.out_char = ch;
            c.last_char = lastc;
            c.binary_seen = bin;
            want_chars.push_back(c);
        endfunction

        function logic [7:0] hex_digit(logic [3:0] n);
            if (n < 4'd10)
                return CH_ZERO + {4'h0, n};
            return CH_HEX_A + {4'h0, n} - 8'd10;
        endfunction

        function int seq_len(logic [7:0] c);
            if (c >= LEAD2_LO && c <= LEAD2_HI)
                return 2;
            if (c >= LEAD3_LO && c <= LEAD3_HI)
                return 3;
            if (c >= LEAD4_LO && c <= LEAD4_HI)
                return 4;
            return 0;
        endfunction

        function seq_verdict_t judge(logic [7:0] p[4], int len, bit at_end);
            int w;
            int j;
            w = seq_len(p[0]);
            if (w == 0)
                return SEQ_BROKEN;
            for (j = 1; j < len && j < w; j++)
            begin
                if ((p[j] & CONT_MASK) != 8'h80)
                    return SEQ_BROKEN;
                if (j == 1)
                begin
                    if (w == 3 && ((p[0] == LEAD3_LO && p[1] < CONT_A0) ||
                                   (p[0] == LEAD_SURR && p[1] >= CONT_A0)))
                        return SEQ_BROKEN;
                    if (w == 4 && ((p[0] == LEAD4_LO && p[1] < CONT_90) ||
                                   (p[0] == LEAD4_HI && p[1] > CONT_8F)))
                        return SEQ_BROKEN;
                end
            end
            if (len >= w)
                return SEQ_COMPLETE;
            return at_end ? SEQ_BROKEN : SEQ_PARTIAL;
        endfunction

        function void predict_word(jsu_item_t w);
            logic [7:0]   pend[4];
            int           len;
            int           used;
            int           j;
            logic [7:0]   c;
            seq_verdict_t verdict;
            len = 0;
            for (j = 0; j < 4; j++)
                pend[j] = '0;
            if (w.first_byte || !in_string)
            begin
                held_count = 0;
                binary_flag = 1'b0;
                in_string = 1'b1;
                add(CH_QUOTE);
            end
            if (held_count > 0)
            begin
                pend[0] = held_lead;
                len = 1;
                for (j = 0; j + 1 < held_count && j < 2; j++)
                begin
                    pend[len] = held_cont[j];
                    len++;
                end
            end
            if (!w.no_data)
            begin
                pend[len] = w.data_byte;
                len++;
            end
            while (len > 0)
            begin
                c = pend[0];
                used = 1;
                if (c < 8'h80)
                begin
                    if (c == CH_QUOTE || c == CH_BSLASH)
                    begin
                        add(CH_BSLASH);
                        add(c);
                    end
                    else if (c < CH_SPACE)
                    begin
                        add(CH_BSLASH);
                        add(CH_U);
                        add(CH_ZERO);
                        add(CH_ZERO);
                        add(hex_digit(c[7:4]));
                        add(hex_digit(c[3:0]));
                        if (c == 8'h00)
                            binary_flag = 1'b1;
                    end
                    else
                        add(c);
                end
                else
                begin
                    verdict = judge(pend, len, w.last_byte);
                    if (verdict == SEQ_PARTIAL)
                        break;
                    if (verdict == SEQ_COMPLETE)
                    begin
                        used = seq_len(c);
                        for (j = 0; j < used; j++)
                            add(pend[j]);
                    end
                    else
                    begin
                        add(CH_BSLASH);
                        add(CH_U);
                        add(CH_F);
                        add(CH_F);
                        add(CH_F);
                        add(CH_D);
                        binary_flag = 1'b1;
                    end
                end
                for (j = 0; j + used < len; j++)
                    pend[j] = pend[j + used];
                len -= used;
            end
            if (w.last_byte)
            begin
                add(CH_QUOTE, 1'b1, binary_flag);
                clear_string();
                return;
            end
            if (len > 3)
                len = 3;
            held_count = len;
            held_lead = len > 0 ? pend[0] : 8'h00;
            held_cont[0] = len > 1 ? pend[1] : 8'h00;
            held_cont[1] = len > 2 ? pend[2] : 8'h00;
        endfunction

        function void check_char(jsu_char_t got);
            jsu_char_t want;
            if (want_chars.size() == 0)
            begin
                $error("out_char: expected nothing, actual %h", got.out_char);
                errors++;
                return;
            end
            want = want_chars.pop_front();
            if (got.out_char !== want.out_char)
            begin
                $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
                errors++;
            end
            if (got.last_char !== want.last_char)
            begin
                $error("last_char: expected %b, actual %b", want.last_char, got.last_char);
                errors++;
            end
            if (got.binary_seen !== want.binary_seen)
            begin
                $error("binary_seen: expected %b, actual %b",
                       want.binary_seen, got.binary_seen);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    jsu_item_t byte_data;
    logic      char_valid;
    logic      char_stall;
    jsu_char_t char_data;
    bit        tx_idle;
    bit        rx_idle;

    json_literal_scoreboard literal_sb;

    json_string_utf8_sanitizer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (byte_valid === 1'b1 && byte_stall === 1'b0)
                literal_sb.predict_word(byte_data);
            if (char_valid === 1'b1 && char_stall === 1'b0)
                literal_sb.check_char(char_data);
        end
    end

    // receiver stalls in bursts
    initial
    begin : char_sink
        int stall_left;
        stall_left = 0;
        char_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    char_stall <= 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                char_stall <= 1'b1;
                stall_left = $urandom_range(1, 11);
            end
        end
    end

    function automatic jsu_item_t make_word(logic [7:0] d, logic f, logic l, logic n);
        jsu_item_t w;
        w.data_byte = d;
        w.first_byte = f;
        w.last_byte = l;
        w.no_data = n;
        return w;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    function automatic logic [7:0] lead3();
        case ($urandom_range(0, 2))
            0: return LEAD3_LO;
            1: return LEAD_SURR;
            default: return 8'($urandom_range(LEAD3_LO, LEAD3_HI));
        endcase
    endfunction

    function automatic logic [7:0] lead4();
        case ($urandom_range(0, 2))
            0: return LEAD4_LO;
            1: return LEAD4_HI;
            default: return 8'($urandom_range(LEAD4_LO, LEAD4_HI));
        endcase
    endfunction

    // second byte inside or outside the range the lead allows
    function automatic logic [7:0] second_after(logic [7:0] lead, bit legal);
        if (lead == LEAD3_LO)
            return legal ? 8'($urandom_range(CONT_A0, 8'hbf))
                         : 8'($urandom_range(8'h80, 8'h9f));
        if (lead == LEAD_SURR)
            return legal ? 8'($urandom_range(8'h80, 8'h9f))
                         : 8'($urandom_range(CONT_A0, 8'hbf));
        if (lead == LEAD4_LO)
            return legal ? 8'($urandom_range(CONT_90, 8'hbf))
                         : 8'($urandom_range(8'h80, CONT_8F));
        if (lead == LEAD4_HI)
            return legal ? 8'($urandom_range(8'h80, CONT_8F))
                         : 8'($urandom_range(CONT_90, 8'hbf));
        if (legal)
            return cont_byte();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7f))
                                    : 8'($urandom_range(8'hc0, 8'hff));
    endfunction

    function automatic void add_token(ref logic [7:0] s[$]);
        logic [7:0] lead;
        int         width;
        int         conts;
        int         j;
        case ($urandom_range(0, 19))
            6: s.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
            7: s.push_back(8'($urandom_range(8'h00, 8'h1f)));
            8, 9:
            begin
                s.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                s.push_back(cont_byte());
            end
            10, 11:
            begin
                lead = lead3();
                s.push_back(lead);
                s.push_back(second_after(lead, 1'b1));
                s.push_back(cont_byte());
            end
            12, 13:
            begin
                lead = lead4();
                s.push_back(lead);
                s.push_back(second_after(lead, 1'b1));
                s.push_back(cont_byte());
                s.push_back(cont_byte());
            end
            14:
            begin
                // cut-short sequence
                width = $urandom_range(2, 4);
                lead = (width == 2) ? 8'($urandom_range(LEAD2_LO, LEAD2_HI)) :
                       (width == 3) ? lead3() : lead4();
                s.push_back(lead);
                conts = $urandom_range(0, width - 2);
                for (j = 0; j < conts; j++)
                    s.push_back(j == 0 ? second_after(lead, 1'b1) : cont_byte());
            end
            15:
            begin
                lead = $urandom_range(0, 1) ? lead3() : lead4();
                s.push_back(lead);
                s.push_back(second_after(lead, 1'b0));
                s.push_back(cont_byte());
            end
            16: s.push_back(8'($urandom_range(0, 255)));
            17:
            begin
                case ($urandom_range(0, 2))
                    0: s.push_back(cont_byte());
                    1: s.push_back(8'($urandom_range(8'hc0, 8'hc1)));
                    default: s.push_back(8'($urandom_range(8'hf5, 8'hff)));
                endcase
            end
            default: s.push_back(8'($urandom_range(8'h20, 8'h7e)));
        endcase
    endfunction

    task automatic send_word(input jsu_item_t w);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= w;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    // shaped strings may skip framing or carry empty words
    task automatic send_text(input logic [7:0] s[$], input bit shaped, output int sent);
        bit open_first;
        bit close_last;
        bit flush_empty;
        int i;
        open_first = !(shaped && $urandom_range(0, 11) == 0);
        close_last = !(shaped && $urandom_range(0, 11) == 0);
        flush_empty = shaped && $urandom_range(0, 7) == 0;
        sent = 0;
        if (s.size() == 0)
        begin
            send_word(make_word(8'($urandom_range(0, 255)), open_first, 1'b1, 1'b1));
            sent = 1;
            return;
        end
        for (i = 0; i < s.size(); i++)
        begin
            if (shaped && i > 0 && $urandom_range(0, 9) == 0)
            begin
                send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1));
                sent++;
            end
            send_word(make_word(s[i], i == 0 && open_first,
                                close_last && !flush_empty && i == s.size() - 1, 1'b0));
            sent++;
        end
        if (close_last && flush_empty)
        begin
            send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1));
            sent++;
        end
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (literal_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] text[$];
        int         random_words;
        int         sent;
        int         tokens;
        bit         pressed;
        literal_sb = new();
        rst_n <= 1'b0;
        byte_valid <= 1'b0;
        byte_data <= '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_words = 0;
        pressed = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string
        send_word(make_word(8'h00, 1'b1, 1'b1, 1'b1));
        // escapes and control bytes
        text = '{CH_QUOTE, CH_BSLASH, 8'h00, 8'h1f, 8'h7f, CH_SPACE};
        send_text(text, 1'b0, sent);
        // multibyte edges, overlong and surrogate forms, bad bytes
        text = '{LEAD2_HI, 8'hbf, LEAD3_LO, 8'h9f, LEAD_SURR, CONT_A0, LEAD4_HI, CONT_90,
                 LEAD4_LO, CONT_90, 8'h80, 8'h80, 8'hff};
        send_text(text, 1'b0, sent);
        // word while idle, restart inside a string, empty word, cut at the end
        send_word(make_word(8'he1, 1'b0, 1'b0, 1'b0));
        send_word(make_word(8'h80, 1'b0, 1'b0, 1'b0));
        send_word(make_word(8'hc0, 1'b1, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0, 1'b1));
        send_word(make_word(LEAD4_LO, 1'b0, 1'b1, 1'b0));
        wait_drained();

        while (random_words < 195)
        begin
            if (random_words >= 150)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            if (!pressed && random_words >= 100)
            begin
                wait_drained();
                pressed = 1'b1;
            end
            text.delete();
            tokens = $urandom_range(0, 6);
            repeat (tokens) add_token(text);
            send_text(text, 1'b1, sent);
            random_words += sent;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (literal_sb.errors == 0 && literal_sb.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_utf8_sanitizer.sv
tb/sv/testbench.sv
